[src/ik_pkg.sv]
// Shared types, widths and constants of the arm inverse kinematics core.
`timescale 1ns / 1ps
package ik_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_FRAC_DEF    = 16;

   localparam int COORD_W    = 7;
   localparam int LEN_W      = 10;
   localparam int TICK_W     = 12;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from the word address of the configuration port.
   localparam logic [2:0] REG_BASE_HEIGHT  = 3'd0;
   localparam logic [2:0] REG_UPPER_LEN    = 3'd1;
   localparam logic [2:0] REG_FORE_LEN     = 3'd2;
   localparam logic [2:0] REG_BASE_OFS     = 3'd3;
   localparam logic [2:0] REG_SHOULDER_OFS = 3'd4;
   localparam logic [2:0] REG_ELBOW_OFS    = 3'd5;

   localparam logic [LEN_W-1:0]  BASE_HEIGHT_RST  = 10'd136;
   localparam logic [LEN_W-1:0]  UPPER_LEN_RST    = 10'd288;
   localparam logic [LEN_W-1:0]  FORE_LEN_RST     = 10'd384;
   localparam logic [TICK_W-1:0] BASE_OFS_RST     = 12'd1825;
   localparam logic [TICK_W-1:0] SHOULDER_OFS_RST = 12'd1825;
   localparam logic [TICK_W-1:0] ELBOW_OFS_RST    = 12'd2460;

   // Front-end widths: Q4 coordinates, height difference, signed law-of-cosines terms.
   localparam int Q4_W = 11;
   localparam int DZ_W = 11;
   localparam int N_W  = 24;

   // Square root chain: radicand, root and partial remainder widths.
   localparam int SQ_W     = 46;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int SQ_LANES = 3;

   // CORDIC widths: operand, prescaled datapath, Q30 accumulator and final angle.
   localparam int CIN_W    = 25;
   localparam int CX_W     = 52;
   localparam int CZ_W     = 33;
   localparam int CA_W     = 34;
   localparam int PRESCALE = 24;
   localparam int C_LANES  = 4;
   localparam int ATAN_LEN = 24;

   localparam logic signed [CA_W-1:0] PI_Q30    = 34'sd3373259426;
   localparam logic signed [26:0]     TICK_GAIN = 27'sd42669730;

   localparam logic signed [CZ_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
      33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
      33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
      33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
      33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
      33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
      33'sd1023,      33'sd511,       33'sd255,       33'sd127
   };

   typedef struct packed {
      logic [LEN_W-1:0]  base_height;
      logic [LEN_W-1:0]  upper_len;
      logic [LEN_W-1:0]  fore_len;
      logic [TICK_W-1:0] base_ofs;
      logic [TICK_W-1:0] shoulder_ofs;
      logic [TICK_W-1:0] elbow_ofs;
   } ik_cfg_type;

   typedef struct packed {
      logic above;
      logic bad;
   } ik_side_type;

   typedef struct packed {
      logic signed [Q4_W-1:0] x;
      logic signed [Q4_W-1:0] y;
      logic signed [N_W-1:0]  n;
      logic signed [N_W-1:0]  p;
      logic [DZ_W-1:0]        dz;
      ik_side_type            side;
   } ik_sq_tag_type;

   typedef struct packed {
      logic [SQ_W-1:0]   num;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } ik_sq_lane_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
      logic                   yzero;
      logic                   xneg;
      logic                   yneg;
   } ik_cordic_lane_type;

   typedef struct packed {
      logic [TICK_W-1:0] base_ticks;
      logic [TICK_W-1:0] shoulder_ticks;
      logic [TICK_W-1:0] elbow_ticks;
      logic              unreachable;
   } ik_result_type;

   // Prescales an (y, x) pair and folds x into the right half plane.
   function automatic ik_cordic_lane_type cordic_prep(input logic signed [CIN_W-1:0] y,
                                                      input logic signed [CIN_W-1:0] x);
      ik_cordic_lane_type l;
      logic signed [CX_W-1:0] xs;
      logic signed [CX_W-1:0] ys;
      xs = CX_W'(x) <<< PRESCALE;
      ys = CX_W'(y) <<< PRESCALE;
      l.x     = x[CIN_W-1] ? -xs : xs;
      l.y     = ys;
      l.z     = '0;
      l.yzero = (y == '0);
      l.xneg  = x[CIN_W-1];
      l.yneg  = y[CIN_W-1];
      return l;
   endfunction

   // Restores the full-quadrant angle in Q30 from the right half plane result.
   function automatic logic signed [CA_W-1:0] cordic_angle(input ik_cordic_lane_type l);
      logic signed [CA_W-1:0] core;
      logic signed [CA_W-1:0] a;
      core = l.yzero ? '0 : CA_W'(l.z);
      if (!l.xneg) begin
         a = core;
      end else if (!l.yneg) begin
         a = PI_Q30 - core;
      end else begin
         a = -PI_Q30 - core;
      end
      return a;
   endfunction

endpackage

[src/ik_req_if.sv]
// Target point channel: valid, ready and the three coordinates.
`timescale 1ns / 1ps
interface ik_req_if import ik_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   logic signed [COORD_W-1:0] target_z;

   modport source (output valid, output target_x, output target_y, output target_z,
                   input ready);
   modport sink (input valid, input target_x, input target_y, input target_z,
                 output ready);
endinterface

[src/ik_rsp_if.sv]
// Servo goal channel: valid, ready, three tick values and the unreachable flag.
`timescale 1ns / 1ps
interface ik_rsp_if import ik_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] base_ticks;
   logic [TICK_W-1:0] shoulder_ticks;
   logic [TICK_W-1:0] elbow_ticks;
   logic              unreachable;

   modport source (output valid, output base_ticks, output shoulder_ticks,
                   output elbow_ticks, output unreachable, input ready);
   modport sink (input valid, input base_ticks, input shoulder_ticks,
                 input elbow_ticks, input unreachable, output ready);
endinterface

[src/ik_front.sv]
// Five-stage front end: squares, law-of-cosines terms and square root radicands.
`timescale 1ns / 1ps
module ik_front import ik_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [COORD_W-1:0]        in_x,
   input  logic signed [COORD_W-1:0]        in_y,
   input  logic signed [COORD_W-1:0]        in_z,
   input  ik_cfg_type                       cfg,
   output logic                             out_valid,
   output ik_sq_lane_type [SQ_LANES-1:0]    out_lane,
   output ik_sq_tag_type                    out_tag
);

   typedef struct packed {
      logic signed [Q4_W-1:0] x;
      logic signed [Q4_W-1:0] y;
      logic [DZ_W-1:0]        dz;
      logic                   above;
      logic                   lzero;
      logic [20:0]            xx;
      logic [20:0]            yy;
      logic [21:0]            dd;
      logic [19:0]            l1sq;
      logic [19:0]            l2sq;
      logic [19:0]            l12;
   } st_a_type;

   typedef struct packed {
      logic signed [Q4_W-1:0] x;
      logic signed [Q4_W-1:0] y;
      logic [DZ_W-1:0]        dz;
      logic                   above;
      logic                   lzero;
      logic [21:0]            rr;
      logic [22:0]            d2;
      logic [19:0]            l1sq;
      logic [19:0]            l2sq;
      logic [20:0]            m;
   } st_b_type;

   typedef struct packed {
      logic signed [Q4_W-1:0] x;
      logic signed [Q4_W-1:0] y;
      logic [DZ_W-1:0]        dz;
      logic                   above;
      logic                   bad0;
      logic [21:0]            rr;
      logic signed [N_W-1:0]  n;
      logic signed [N_W-1:0]  p;
      logic [20:0]            m;
      logic [44:0]            q;
   } st_c_type;

   typedef struct packed {
      logic signed [Q4_W-1:0] x;
      logic signed [Q4_W-1:0] y;
      logic [DZ_W-1:0]        dz;
      logic                   above;
      logic                   bad0;
      logic [21:0]            rr;
      logic signed [N_W-1:0]  n;
      logic signed [N_W-1:0]  p;
      logic [45:0]            nn;
      logic [41:0]            mm;
      logic [45:0]            pp;
      logic [44:0]            q;
   } st_d_type;

   st_a_type a_ff, a_in;
   st_b_type b_ff, b_in;
   st_c_type c_ff, c_in;
   st_d_type d_ff, d_in;
   ik_sq_lane_type [SQ_LANES-1:0] lane_ff, lane_in;
   ik_sq_tag_type                 tag_ff, tag_in;
   logic [4:0]                    valid_ff;

   logic signed [Q4_W-1:0] xq, yq, zq;
   logic signed [Q4_W:0]   zs, hs;
   logic signed [21:0]     xx_full, yy_full;
   logic [42:0]            l1d2;
   logic signed [47:0]     nn_full, pp_full;

   always_comb begin
      xq = {in_x, 4'b0000};
      yq = {in_y, 4'b0000};
      zq = {in_z, 4'b0000};
      zs = (Q4_W + 1)'(zq);
      hs = $signed({2'b00, cfg.base_height});
      xx_full = xq * xq;
      yy_full = yq * yq;
      a_in.x     = xq;
      a_in.y     = yq;
      a_in.above = zs > hs;
      a_in.dz    = a_in.above ? DZ_W'(zs - hs) : DZ_W'(hs - zs);
      a_in.lzero = (cfg.upper_len == '0) || (cfg.fore_len == '0);
      a_in.xx    = xx_full[20:0];
      a_in.yy    = yy_full[20:0];
      a_in.dd    = a_in.dz * a_in.dz;
      a_in.l1sq  = cfg.upper_len * cfg.upper_len;
      a_in.l2sq  = cfg.fore_len * cfg.fore_len;
      a_in.l12   = cfg.upper_len * cfg.fore_len;
   end

   always_comb begin
      b_in.x     = a_ff.x;
      b_in.y     = a_ff.y;
      b_in.dz    = a_ff.dz;
      b_in.above = a_ff.above;
      b_in.lzero = a_ff.lzero;
      b_in.rr    = 22'(a_ff.xx) + 22'(a_ff.yy);
      b_in.d2    = 23'(a_ff.xx) + 23'(a_ff.yy) + 23'(a_ff.dd);
      b_in.l1sq  = a_ff.l1sq;
      b_in.l2sq  = a_ff.l2sq;
      b_in.m     = {a_ff.l12, 1'b0};
   end

   always_comb begin
      l1d2 = b_ff.l1sq * b_ff.d2;
      c_in.x     = b_ff.x;
      c_in.y     = b_ff.y;
      c_in.dz    = b_ff.dz;
      c_in.above = b_ff.above;
      c_in.bad0  = b_ff.lzero || (b_ff.d2 == '0);
      c_in.rr    = b_ff.rr;
      c_in.n     = N_W'(b_ff.l1sq) + N_W'(b_ff.l2sq) - N_W'(b_ff.d2);
      c_in.p     = N_W'(b_ff.l1sq) + N_W'(b_ff.d2) - N_W'(b_ff.l2sq);
      c_in.m     = b_ff.m;
      c_in.q     = {l1d2, 2'b00};
   end

   always_comb begin
      nn_full = c_ff.n * c_ff.n;
      pp_full = c_ff.p * c_ff.p;
      d_in.x     = c_ff.x;
      d_in.y     = c_ff.y;
      d_in.dz    = c_ff.dz;
      d_in.above = c_ff.above;
      d_in.bad0  = c_ff.bad0;
      d_in.rr    = c_ff.rr;
      d_in.n     = c_ff.n;
      d_in.p     = c_ff.p;
      d_in.nn    = nn_full[45:0];
      d_in.mm    = c_ff.m * c_ff.m;
      d_in.pp    = pp_full[45:0];
      d_in.q     = c_ff.q;
   end

   // Lane 0: elbow sine term, lane 1: shoulder triangle term, lane 2: planar radius in Q12.
   always_comb begin
      lane_in[0].num = SQ_W'(d_ff.mm) - d_ff.nn;
      lane_in[1].num = SQ_W'(d_ff.q) - d_ff.pp;
      lane_in[2].num = SQ_W'({d_ff.rr, 16'b0});
      for (int k = 0; k < SQ_LANES; k++) begin
         lane_in[k].rem  = '0;
         lane_in[k].root = '0;
      end
      tag_in.x          = d_ff.x;
      tag_in.y          = d_ff.y;
      tag_in.n          = d_ff.n;
      tag_in.p          = d_ff.p;
      tag_in.dz         = d_ff.dz;
      tag_in.side.above = d_ff.above;
      tag_in.side.bad   = d_ff.bad0 || (d_ff.nn > SQ_W'(d_ff.mm)) || (d_ff.pp > SQ_W'(d_ff.q));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
         lane_ff <= lane_in;
         tag_ff  <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   assign out_valid = valid_ff[4];
   assign out_lane  = lane_ff;
   assign out_tag   = tag_ff;

endmodule

[src/ik_sqrt_cell.sv]
// One digit step of the pipelined integer square root, three lanes wide.
`timescale 1ns / 1ps
module ik_sqrt_cell import ik_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  ik_sq_lane_type [SQ_LANES-1:0] in_lane,
   input  ik_sq_tag_type                 in_tag,
   output logic                          out_valid,
   output ik_sq_lane_type [SQ_LANES-1:0] out_lane,
   output ik_sq_tag_type                 out_tag
);

   ik_sq_lane_type [SQ_LANES-1:0] lane_ff, lane_in;
   ik_sq_tag_type                 tag_ff;
   logic                          valid_ff;
   logic [REM_W-1:0]              cur [SQ_LANES];
   logic [REM_W-1:0]              trial [SQ_LANES];

   // Bring down the next two radicand bits and try a one for this root bit.
   always_comb begin
      for (int k = 0; k < SQ_LANES; k++) begin
         cur[k]   = {in_lane[k].rem[REM_W-3:0], in_lane[k].num[SQ_W-1:SQ_W-2]};
         trial[k] = REM_W'({in_lane[k].root, 2'b01});
         lane_in[k].num = {in_lane[k].num[SQ_W-3:0], 2'b00};
         if (cur[k] >= trial[k]) begin
            lane_in[k].rem  = cur[k] - trial[k];
            lane_in[k].root = {in_lane[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            lane_in[k].rem  = cur[k];
            lane_in[k].root = {in_lane[k].root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         tag_ff  <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_tag   = tag_ff;

endmodule

[src/ik_cordic_cell.sv]
// One micro-rotation of the vectoring CORDIC, four angle lanes wide.
`timescale 1ns / 1ps
module ik_cordic_cell import ik_pkg::*; #(
   parameter int                     SHIFT = 0,
   parameter logic signed [CZ_W-1:0] ATAN  = ATAN_Q30[0]
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  ik_cordic_lane_type [C_LANES-1:0]  in_lane,
   input  ik_side_type                       in_side,
   output logic                              out_valid,
   output ik_cordic_lane_type [C_LANES-1:0]  out_lane,
   output ik_side_type                       out_side
);

   ik_cordic_lane_type [C_LANES-1:0] lane_ff, lane_in;
   ik_side_type                      side_ff;
   logic                             valid_ff;
   logic signed [CX_W-1:0]           xs [C_LANES];
   logic signed [CX_W-1:0]           ys [C_LANES];

   // A lane whose y operand was zero keeps a zero accumulator throughout.
   always_comb begin
      for (int k = 0; k < C_LANES; k++) begin
         xs[k] = in_lane[k].x >>> SHIFT;
         ys[k] = in_lane[k].y >>> SHIFT;
         lane_in[k] = in_lane[k];
         if (!in_lane[k].y[CX_W-1]) begin
            lane_in[k].x = in_lane[k].x + ys[k];
            lane_in[k].y = in_lane[k].y - xs[k];
            if (!in_lane[k].yzero) begin
               lane_in[k].z = in_lane[k].z + ATAN;
            end
         end else begin
            lane_in[k].x = in_lane[k].x - ys[k];
            lane_in[k].y = in_lane[k].y + xs[k];
            if (!in_lane[k].yzero) begin
               lane_in[k].z = in_lane[k].z - ATAN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         side_ff <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_side  = side_ff;

endmodule

[src/ik_ticks.sv]
// Joint angle assembly and conversion to saturated servo ticks, three stages.
`timescale 1ns / 1ps
module ik_ticks import ik_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [ANGLE_FRAC_BITS+3:0] in_base,
   input  logic signed [ANGLE_FRAC_BITS+3:0] in_qsi,
   input  logic signed [ANGLE_FRAC_BITS+3:0] in_beta,
   input  logic signed [ANGLE_FRAC_BITS+3:0] in_alpha,
   input  ik_side_type                      in_side,
   input  ik_cfg_type                       cfg,
   output logic                             out_valid,
   output ik_result_type                    out_result
);

   localparam int TH_W   = ANGLE_FRAC_BITS + 5;
   localparam int PROD_W = TH_W + 27;
   localparam int OUT_SH = ANGLE_FRAC_BITS + 16;
   localparam logic signed [TH_W-1:0] PI_F =
      TH_W'((PI_Q30 + (CA_W'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS));
   localparam logic signed [PROD_W-1:0] HALF_T = PROD_W'(1) <<< (ANGLE_FRAC_BITS + 15);

   logic signed [TH_W-1:0]   th_ff [3];
   logic signed [TH_W-1:0]   th_in [3];
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [PROD_W-1:0] sum [3];
   logic signed [PROD_W-1:0] shifted [3];
   logic signed [17:0]       t [3];
   logic [TICK_W-1:0]        sat [3];
   logic [TICK_W-1:0]        ofs [3];
   logic                     bad_ff [2];
   ik_result_type            result_ff, result_in;
   logic [2:0]               valid_ff;

   always_comb begin
      th_in[0] = TH_W'(in_base);
      th_in[1] = in_side.above ? TH_W'(in_alpha) + TH_W'(in_beta)
                               : TH_W'(in_beta) - TH_W'(in_alpha);
      th_in[2] = TH_W'(in_qsi) - PI_F;
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = th_ff[k] * TICK_GAIN;
      end
   end

   always_comb begin
      ofs[0] = cfg.base_ofs;
      ofs[1] = cfg.shoulder_ofs;
      ofs[2] = cfg.elbow_ofs;
      for (int k = 0; k < 3; k++) begin
         sum[k]     = prod_ff[k] + HALF_T;
         shifted[k] = sum[k] >>> OUT_SH;
         t[k]       = $signed(shifted[k][17:0]) + 18'($signed({1'b0, ofs[k]}));
         if (t[k][17]) begin
            sat[k] = '0;
         end else if (t[k] > 18'sd4095) begin
            sat[k] = '1;
         end else begin
            sat[k] = t[k][TICK_W-1:0];
         end
      end
      result_in.base_ticks     = sat[0];
      result_in.shoulder_ticks = bad_ff[1] ? '0 : sat[1];
      result_in.elbow_ticks    = bad_ff[1] ? '0 : sat[2];
      result_in.unreachable    = bad_ff[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         th_ff     <= th_in;
         prod_ff   <= prod_in;
         bad_ff[0] <= in_side.bad;
         bad_ff[1] <= bad_ff[0];
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid  = valid_ff[2];
   assign out_result = result_ff;

endmodule

[src/arm_inverse_kinematics_core.sv]
// Top level of the three-joint arm inverse kinematics core.
//
// A target point (x, y, z) enters on the req channel and the base, shoulder and
// elbow servo goals leave on the rsp channel, one result per target, in order.
// Points out of reach set unreachable and force the shoulder and elbow goals to
// zero; the base goal is still computed.
// The datapath is one pipeline: five front stages of squares and products, a
// row of 23 square root cells, one CORDIC setup stage, CORDIC_STAGES rotation
// cells, one angle stage and three tick stages. A new target is taken every
// cycle while the output is not stalled.
// When the receiver holds rsp.ready low with a result waiting, the whole row of
// cells holds its contents and req.ready drops in the same cycle; no data is
// lost. Reset empties the pipeline and loads the register defaults.
// Registers sit at byte address 4*i of the APB-style port in the order base
// height, upper link, fore link, base, shoulder and elbow offsets. Write them
// only while no transaction is in flight.
`timescale 1ns / 1ps
module arm_inverse_kinematics_core import ik_pkg::*; #(
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ik_req_if.sink                req,
   ik_rsp_if.source              rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ANG_W = ANGLE_FRAC_BITS + 4;
   localparam int RSH   = 30 - ANGLE_FRAC_BITS;
   localparam logic signed [CA_W-1:0] HALF_A = CA_W'(1) <<< (RSH - 1);

   ik_cfg_type cfg_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;
   logic       adv;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_height  <= BASE_HEIGHT_RST;
         cfg_ff.upper_len    <= UPPER_LEN_RST;
         cfg_ff.fore_len     <= FORE_LEN_RST;
         cfg_ff.base_ofs     <= BASE_OFS_RST;
         cfg_ff.shoulder_ofs <= SHOULDER_OFS_RST;
         cfg_ff.elbow_ofs    <= ELBOW_OFS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BASE_HEIGHT:  cfg_ff.base_height  <= csr_pwdata[LEN_W-1:0];
            REG_UPPER_LEN:    cfg_ff.upper_len    <= csr_pwdata[LEN_W-1:0];
            REG_FORE_LEN:     cfg_ff.fore_len     <= csr_pwdata[LEN_W-1:0];
            REG_BASE_OFS:     cfg_ff.base_ofs     <= csr_pwdata[TICK_W-1:0];
            REG_SHOULDER_OFS: cfg_ff.shoulder_ofs <= csr_pwdata[TICK_W-1:0];
            REG_ELBOW_OFS:    cfg_ff.elbow_ofs    <= csr_pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BASE_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.base_height);
         REG_UPPER_LEN:    csr_prdata = CSR_DATA_W'(cfg_ff.upper_len);
         REG_FORE_LEN:     csr_prdata = CSR_DATA_W'(cfg_ff.fore_len);
         REG_BASE_OFS:     csr_prdata = CSR_DATA_W'(cfg_ff.base_ofs);
         REG_SHOULDER_OFS: csr_prdata = CSR_DATA_W'(cfg_ff.shoulder_ofs);
         REG_ELBOW_OFS:    csr_prdata = CSR_DATA_W'(cfg_ff.elbow_ofs);
         default:          csr_prdata = '0;
      endcase
   end

   // The pipeline moves whenever the output register is empty or being drained.
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   ik_sq_lane_type [SQ_LANES-1:0] sq_lane [0:ROOT_W];
   ik_sq_tag_type                 sq_tag [0:ROOT_W];
   logic [ROOT_W:0]               sq_valid;

   ik_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req.valid),
      .in_x      (req.target_x),
      .in_y      (req.target_y),
      .in_z      (req.target_z),
      .cfg       (cfg_ff),
      .out_valid (sq_valid[0]),
      .out_lane  (sq_lane[0]),
      .out_tag   (sq_tag[0])
   );

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      ik_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_valid[g]),
         .in_lane   (sq_lane[g]),
         .in_tag    (sq_tag[g]),
         .out_valid (sq_valid[g+1]),
         .out_lane  (sq_lane[g+1]),
         .out_tag   (sq_tag[g+1])
      );
   end

   ik_cordic_lane_type [C_LANES-1:0] cd_lane [0:CORDIC_STAGES];
   ik_side_type                      cd_side [0:CORDIC_STAGES];
   logic [CORDIC_STAGES:0]           cd_valid;
   ik_cordic_lane_type [C_LANES-1:0] prep_in;
   ik_cordic_lane_type [C_LANES-1:0] prep_lane_ff;
   ik_side_type                      prep_side_ff;
   logic                             prep_valid_ff;
   ik_sq_tag_type                    sq_last_tag;
   ik_sq_lane_type [SQ_LANES-1:0]    sq_last_lane;

   // Lanes: base atan2(y, x), elbow triangle, shoulder triangle, elevation.
   always_comb begin
      sq_last_tag  = sq_tag[ROOT_W];
      sq_last_lane = sq_lane[ROOT_W];
      prep_in[0] = cordic_prep(CIN_W'(sq_last_tag.y), CIN_W'(sq_last_tag.x));
      prep_in[1] = cordic_prep(CIN_W'(sq_last_lane[0].root), CIN_W'(sq_last_tag.n));
      prep_in[2] = cordic_prep(CIN_W'(sq_last_lane[1].root), CIN_W'(sq_last_tag.p));
      prep_in[3] = cordic_prep(CIN_W'({sq_last_tag.dz, 8'b0}), CIN_W'(sq_last_lane[2].root));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_lane_ff <= prep_in;
         prep_side_ff <= sq_last_tag.side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= sq_valid[ROOT_W];
      end
   end

   assign cd_lane[0]  = prep_lane_ff;
   assign cd_side[0]  = prep_side_ff;
   assign cd_valid[0] = prep_valid_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      ik_cordic_cell #(
         .SHIFT (g),
         .ATAN  (ATAN_Q30[g])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (cd_valid[g]),
         .in_lane   (cd_lane[g]),
         .in_side   (cd_side[g]),
         .out_valid (cd_valid[g+1]),
         .out_lane  (cd_lane[g+1]),
         .out_side  (cd_side[g+1])
      );
   end

   logic signed [CA_W-1:0]  a_sum [C_LANES];
   logic signed [CA_W-1:0]  a_rnd [C_LANES];
   logic signed [ANG_W-1:0] ang_in [C_LANES];
   logic signed [ANG_W-1:0] ang_ff [C_LANES];
   ik_side_type             ang_side_ff;
   logic                    ang_valid_ff;

   // Restore the quadrant and round the Q30 angle to the working fraction.
   always_comb begin
      for (int k = 0; k < C_LANES; k++) begin
         a_sum[k]  = cordic_angle(cd_lane[CORDIC_STAGES][k]) + HALF_A;
         a_rnd[k]  = a_sum[k] >>> RSH;
         ang_in[k] = a_rnd[k][ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff      <= ang_in;
         ang_side_ff <= cd_side[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_valid_ff <= 1'b0;
      end else if (adv) begin
         ang_valid_ff <= cd_valid[CORDIC_STAGES];
      end
   end

   ik_result_type result;

   ik_ticks #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_ticks (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (ang_valid_ff),
      .in_base    (ang_ff[0]),
      .in_qsi     (ang_ff[1]),
      .in_beta    (ang_ff[2]),
      .in_alpha   (ang_ff[3]),
      .in_side    (ang_side_ff),
      .cfg        (cfg_ff),
      .out_valid  (rsp.valid),
      .out_result (result)
   );

   assign rsp.base_ticks     = result.base_ticks;
   assign rsp.shoulder_ticks = result.shoulder_ticks;
   assign rsp.elbow_ticks    = result.elbow_ticks;
   assign rsp.unreachable    = result.unreachable;

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.unreachable |-> rsp.shoulder_ticks == '0 && rsp.elbow_ticks == '0)
      else $error("unreachable result carries nonzero shoulder or elbow goal");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cd_valid) && $stable(sq_valid))
      else $error("pipeline moved while the output was stalled");

endmodule
